// ----- rtl/assert_macros.svh -----
// Assertion helpers shared by the RTL modules.
// Each module that uses them has a clock named clk and an active-low reset named rst_n.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checks a property at every rising clock edge, except while reset is active.
`define ASSERT_CLK(label, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("%m: assertion failed");

// Checks that a condition never holds.
`define ASSERT_NEVER(label, expr) `ASSERT_CLK(label, !(expr))

`endif

// ----- rtl/tfs_pkg.sv -----
package tfs_pkg;

  // Operation codes of an input word.
  typedef enum logic [3:0] {
    OP_INT8     = 4'd0,
    OP_INT16    = 4'd1,
    OP_INT32    = 4'd2,
    OP_INT64    = 4'd3,
    OP_HALF     = 4'd4,
    OP_SINGLE   = 4'd5,
    OP_DOUBLE   = 4'd6,
    OP_STR_LEN  = 4'd7,
    OP_RAW_BYTE = 4'd8
  } tfs_op_t;

  localparam int TFS_QUEUE_DEPTH = 4;
  localparam int TFS_MAX_BYTES   = 8;
  localparam int TFS_NBYTES_W    = 4;

  // Exponent bias and largest biased exponent of each float target.
  localparam logic signed [12:0] HALF_BIAS   = 13'sd15;
  localparam logic signed [12:0] HALF_EMAX   = 13'sd30;
  localparam logic signed [12:0] SINGLE_BIAS = 13'sd127;
  localparam logic signed [12:0] SINGLE_EMAX = 13'sd254;
  localparam logic signed [12:0] DOUBLE_BIAS = 13'sd1023;
  localparam logic signed [12:0] DOUBLE_EMAX = 13'sd2046;

  // One encoded field, left-aligned so the first byte sits in the top bits.
  typedef struct packed {
    logic [63:0]             word;
    logic [TFS_NBYTES_W-1:0] nbytes;
    logic                    err;
  } tfs_item_t;

  // Leading zeros of one byte; 8 when the byte is zero.
  function automatic logic [3:0] lzc8(input logic [7:0] b);
    logic [3:0] n;
    n = 4'd8;
    for (int i = 0; i < 8; i++) begin
      if (b[i]) begin
        n = 4'(7 - i);
      end
    end
    return n;
  endfunction

endpackage

// ----- rtl/tfs_queue.sv -----
`include "assert_macros.svh"

module tfs_queue #(
  parameter int Depth = tfs_pkg::TFS_QUEUE_DEPTH
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                push,
  input  tfs_pkg::tfs_item_t  push_item,
  output logic                full,
  input  logic                pop,
  output tfs_pkg::tfs_item_t  rd_item,
  output logic                rd_valid
);
  import tfs_pkg::*;

  localparam int PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int CntW = $clog2(Depth + 1);

  tfs_item_t       mem_r [Depth];
  logic [PtrW-1:0] wr_ptr_r;
  logic [PtrW-1:0] rd_ptr_r;
  logic [CntW-1:0] cnt_r;
  logic            do_push;
  logic            do_pop;

  assign full     = (cnt_r == CntW'(Depth));
  assign rd_valid = (cnt_r != '0);
  assign do_push  = push && !full;
  assign do_pop   = pop && rd_valid;
  assign rd_item  = mem_r[rd_ptr_r];

  // Storage holds payload only.
  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_item;
    end
  end

  // Pointers and fill count.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= (wr_ptr_r == PtrW'(Depth - 1)) ? '0 : wr_ptr_r + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_r <= (rd_ptr_r == PtrW'(Depth - 1)) ? '0 : rd_ptr_r + 1'b1;
      end
      case ({do_push, do_pop})
        2'b10:   cnt_r <= cnt_r + 1'b1;
        2'b01:   cnt_r <= cnt_r - 1'b1;
        default: cnt_r <= cnt_r;
      endcase
    end
  end

  `ASSERT_NEVER(a_q_overfill, cnt_r > CntW'(Depth))
  `ASSERT_CLK(a_q_count, (do_push && !do_pop) |=> (cnt_r == $past(cnt_r) + 1'b1))

endmodule

// ----- rtl/tfs_front.sv -----
module tfs_front (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [3:0]         in_operation,
  input  logic [63:0]        in_value,
  output logic               push,
  output tfs_pkg::tfs_item_t push_item,
  input  logic               q_full
);
  import tfs_pkg::*;

  logic advance;

  // Stage registers: input, group counts, leading zeros, normalized, encoded.
  logic              v1_r, v2_r, v3_r, v4_r, v5_r;
  logic [3:0]        op1_r, op2_r, op3_r, op4_r;
  logic [63:0]       val1_r, val2_r, val3_r, val4_r;
  logic [3:0]        grp_lz2_r [7];
  logic [5:0]        lz3_r;
  logic [51:0]       frn4_r;
  logic signed [11:0] e4_r;
  logic              zero4_r;
  logic              special4_r;
  tfs_item_t         item5_r;
  logic              keep5_r;

  logic [55:0]       pad_c;
  logic [3:0]        grp_lz_c [7];
  logic [5:0]        lz_c;
  logic              found_c;
  logic [10:0]       ex3_c;
  logic [51:0]       fr3_c;
  logic [51:0]       frn_c;
  logic signed [11:0] e_c;
  logic signed [12:0] b_h, b_s, b_d;
  logic [63:0]       sum_h;
  logic [76:0]       sum_s;
  logic [10:0]       sig_h;
  logic [23:0]       sig_s;
  logic              sign4_c;
  logic              err_h, err_s, err_d;
  tfs_item_t         item_c;
  logic              keep_c;

  // The whole pipeline moves unless an encoded word waits on a full queue.
  assign advance   = !(v5_r && keep5_r && q_full);
  assign in_stall  = !advance;
  assign push      = v5_r && keep5_r && !q_full;
  assign push_item = item5_r;

  // Leading zeros of each byte of the fraction, padded to seven bytes.
  always_comb begin
    pad_c = {val1_r[51:0], 4'b0};
    for (int g = 0; g < 7; g++) begin
      grp_lz_c[g] = lzc8(pad_c[55 - 8*g -: 8]);
    end
  end

  // First nonzero byte gives the leading zero count of the fraction.
  always_comb begin
    lz_c    = '0;
    found_c = 1'b0;
    for (int g = 0; g < 7; g++) begin
      if (!found_c && grp_lz2_r[g] != 4'd8) begin
        lz_c    = 6'(8*g) + {2'b0, grp_lz2_r[g]};
        found_c = 1'b1;
      end
    end
  end

  // Normalize subnormals and unbias the exponent.
  always_comb begin
    ex3_c = val3_r[62:52];
    fr3_c = val3_r[51:0];
    if (ex3_c == '0) begin
      frn_c = fr3_c << ({1'b0, lz3_r} + 7'd1);
      e_c   = -12'sd1023 - $signed({6'b0, lz3_r});
    end else begin
      frn_c = fr3_c;
      e_c   = $signed({1'b0, ex3_c}) - 12'sd1023;
    end
  end

  // Rebias, truncate the fraction and place the field in the top bytes.
  // The cut fraction can reach 2^sb; it is ORed into the exponent field.
  always_comb begin
    sign4_c = val4_r[63];
    b_h     = {e4_r[11], e4_r} + HALF_BIAS;
    b_s     = {e4_r[11], e4_r} + SINGLE_BIAS;
    b_d     = {e4_r[11], e4_r} + DOUBLE_BIAS;
    sum_h   = {1'b0, frn4_r, 11'b0} + {12'b0, frn4_r};
    sum_s   = {1'b0, frn4_r, 24'b0} + {25'b0, frn4_r};
    sig_h   = sum_h[63:53];
    sig_s   = sum_s[76:53];
    err_h   = special4_r || (!zero4_r && (b_h < 13'sd1 || b_h > HALF_EMAX));
    err_s   = special4_r || (!zero4_r && (b_s < 13'sd1 || b_s > SINGLE_EMAX));
    err_d   = special4_r || (!zero4_r && (b_d < 13'sd1 || b_d > DOUBLE_EMAX));
    item_c  = '0;
    keep_c  = 1'b1;
    case (tfs_op_t'(op4_r))
      OP_INT8, OP_RAW_BYTE: begin
        item_c.word   = {val4_r[7:0], 56'b0};
        item_c.nbytes = TFS_NBYTES_W'(1);
      end
      OP_INT16, OP_STR_LEN: begin
        item_c.word   = {val4_r[15:0], 48'b0};
        item_c.nbytes = TFS_NBYTES_W'(2);
      end
      OP_INT32: begin
        item_c.word   = {val4_r[31:0], 32'b0};
        item_c.nbytes = TFS_NBYTES_W'(4);
      end
      OP_INT64: begin
        item_c.word   = val4_r;
        item_c.nbytes = TFS_NBYTES_W'(8);
      end
      OP_HALF: begin
        item_c.nbytes = TFS_NBYTES_W'(2);
        item_c.err    = err_h;
        if (!err_h && !zero4_r) begin
          item_c.word = {{sign4_c, b_h[4:0], 10'b0} | {5'b0, sig_h}, 48'b0};
        end
      end
      OP_SINGLE: begin
        item_c.nbytes = TFS_NBYTES_W'(4);
        item_c.err    = err_s;
        if (!err_s && !zero4_r) begin
          item_c.word = {{sign4_c, b_s[7:0], 23'b0} | {8'b0, sig_s}, 32'b0};
        end
      end
      OP_DOUBLE: begin
        item_c.nbytes = TFS_NBYTES_W'(8);
        item_c.err    = err_d;
        if (!err_d && !zero4_r) begin
          item_c.word = {sign4_c, b_d[10:0], frn4_r};
        end
      end
      default: begin
        keep_c = 1'b0;
      end
    endcase
  end

  // Stage valid bits.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
      v5_r <= 1'b0;
    end else if (advance) begin
      v1_r <= in_valid;
      v2_r <= v1_r;
      v3_r <= v2_r;
      v4_r <= v3_r;
      v5_r <= v4_r;
    end
  end

  // Stage payload.
  always_ff @(posedge clk) begin
    if (advance) begin
      op1_r      <= in_operation;
      val1_r     <= in_value;
      op2_r      <= op1_r;
      val2_r     <= val1_r;
      grp_lz2_r  <= grp_lz_c;
      op3_r      <= op2_r;
      val3_r     <= val2_r;
      lz3_r      <= lz_c;
      op4_r      <= op3_r;
      val4_r     <= val3_r;
      frn4_r     <= frn_c;
      e4_r       <= e_c;
      zero4_r    <= (ex3_c == '0) && (fr3_c == '0);
      special4_r <= (ex3_c == 11'h7FF);
      item5_r    <= item_c;
      keep5_r    <= keep_c;
    end
  end

endmodule

// ----- rtl/tfs_back.sv -----
`include "assert_macros.svh"

module tfs_back (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               q_valid,
  input  tfs_pkg::tfs_item_t q_item,
  output logic               q_pop,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [7:0]         out_byte,
  output logic               out_last,
  output logic [31:0]        out_byte_total,
  output logic               out_range_error
);
  import tfs_pkg::*;

  logic                    cur_valid_r;
  logic [63:0]             cur_word_r;
  logic [TFS_NBYTES_W-1:0] cur_left_r;
  logic                    cur_err_r;
  logic [31:0]             count_r;
  logic [31:0]             count_nxt;
  logic                    out_valid_r;
  logic [7:0]              out_byte_r;
  logic                    out_last_r;
  logic [31:0]             out_total_r;
  logic                    out_err_r;
  logic                    emit;
  logic                    cur_done;

  // A byte moves to the output register whenever that register is free.
  assign emit      = cur_valid_r && (!out_valid_r || !out_stall);
  assign cur_done  = emit && (cur_left_r == TFS_NBYTES_W'(1));
  assign q_pop     = q_valid && (!cur_valid_r || cur_done);
  assign count_nxt = (count_r == '1) ? count_r : count_r + 32'd1;

  assign out_valid       = out_valid_r;
  assign out_byte        = out_byte_r;
  assign out_last        = out_last_r;
  assign out_byte_total  = out_total_r;
  assign out_range_error = out_err_r;

  // Control: current word, running total and output valid.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cur_valid_r <= 1'b0;
      cur_left_r  <= '0;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (q_pop) begin
        cur_valid_r <= 1'b1;
        cur_left_r  <= q_item.nbytes;
      end else if (emit) begin
        cur_valid_r <= !cur_done;
        cur_left_r  <= cur_left_r - 1'b1;
      end
      if (emit) begin
        count_r     <= count_nxt;
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Payload: shift the word a byte at a time into the output register.
  always_ff @(posedge clk) begin
    if (q_pop) begin
      cur_word_r <= q_item.word;
      cur_err_r  <= q_item.err;
    end else if (emit) begin
      cur_word_r <= cur_word_r << 8;
    end
    if (emit) begin
      out_byte_r  <= cur_word_r[63:56];
      out_last_r  <= (cur_left_r == TFS_NBYTES_W'(1));
      out_total_r <= count_nxt;
      out_err_r   <= cur_err_r;
    end
  end

  `ASSERT_CLK(a_left_range,
              cur_valid_r |-> (cur_left_r != '0 && cur_left_r <= TFS_NBYTES_W'(TFS_MAX_BYTES)))
  `ASSERT_CLK(a_field_contig, (out_valid_r && !out_stall && !out_last_r) |=> out_valid_r)
  `ASSERT_CLK(a_total_step, (emit && count_r != '1) |=> (count_r == $past(count_r) + 32'd1))

endmodule

// ----- rtl/typed_field_serializer_core.sv -----
// Typed field serializer.
// Input channel: in_valid / in_stall with in_operation and in_value. One word
// is one field: an 8/16/32/64-bit integer, a half, single or double float
// given as binary64 bits, a 16-bit string length or one raw string byte.
// Unused operation codes are dropped without output.
// Output channel: out_valid / out_stall, one byte per transfer, most significant
// first, with out_last on the final byte of the field, a saturating running
// byte total and out_range_error on every byte of a float that cannot be
// encoded (those fields are sent as zero bits).
// Throughput: one output byte per cycle while out_stall is low and a field is
// ready; a new input word is taken every cycle while the field queue has room.
// A stall on the output holds the output register; the field queue holds
// QueueDepth fields, in addition to the five encoder stages and the field being
// shifted out, before the input stalls. Reset clears all valids, the queue and
// the byte total.
module typed_field_serializer_core #(
  parameter int QueueDepth = tfs_pkg::TFS_QUEUE_DEPTH
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [3:0]  in_operation,
  input  logic [63:0] in_value,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [7:0]  out_byte,
  output logic        out_last,
  output logic [31:0] out_byte_total,
  output logic        out_range_error
);
  import tfs_pkg::*;

  logic      push;
  tfs_item_t push_item;
  logic      q_full;
  logic      q_pop;
  tfs_item_t q_item;
  logic      q_valid;

  // Encoder pipeline.
  tfs_front u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_operation (in_operation),
    .in_value     (in_value),
    .push         (push),
    .push_item    (push_item),
    .q_full       (q_full)
  );

  // Queue of encoded fields.
  tfs_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_item (push_item),
    .full      (q_full),
    .pop       (q_pop),
    .rd_item   (q_item),
    .rd_valid  (q_valid)
  );

  // Byte shifter and output register.
  tfs_back u_back (
    .clk             (clk),
    .rst_n           (rst_n),
    .q_valid         (q_valid),
    .q_item          (q_item),
    .q_pop           (q_pop),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_byte        (out_byte),
    .out_last        (out_last),
    .out_byte_total  (out_byte_total),
    .out_range_error (out_range_error)
  );

endmodule
